/* rtl/core/uule_pkg.sv */
// shared constants, types and helper function of the uuencode line encoder
package uule_pkg;

    localparam int unsigned LINE_BYTES = 45;
    localparam int unsigned MAX_CHARS = 7;
    localparam int unsigned CNT_W = $clog2(MAX_CHARS + 1);

    localparam logic [15:0] BLOCK_BYTES_RST = 16'd512;
    localparam logic [6:0] CHAR_ZERO = 7'h60;
    localparam logic [6:0] CHAR_OFFSET = 7'h20;
    localparam logic [6:0] CHAR_CR = 7'h0d;
    localparam logic [6:0] CHAR_LF = 7'h0a;

    // characters caused by one data byte, oldest in slot 0
    typedef struct packed {
        logic [MAX_CHARS-1:0][6:0] chars;
        logic [CNT_W-1:0]          count;
        logic                      done;
        logic [23:0]               sum;
    } t_burst;

    // six bits to one printable character, zero goes out as a backtick
    function automatic logic [6:0] enc6(input logic [5:0] v);
        logic [6:0] ch;
        ch = (v == 6'd0) ? CHAR_ZERO : ({1'b0, v} + CHAR_OFFSET);
        return ch;
    endfunction

endpackage

/* rtl/core/uule_byte_if.sv */
// input channel: one raw data byte per beat
interface uule_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

/* rtl/core/uule_char_if.sv */
// output channel: one encoded character per beat
interface uule_char_if;
    logic        valid;
    logic        ready;
    logic [6:0]  out_char;
    logic        last_of_run;
    logic        block_done;
    logic [23:0] byte_sum;

    modport source (output valid, output out_char, output last_of_run,
                    output block_done, output byte_sum, input ready);
    modport sink (input valid, input out_char, input last_of_run,
                  input block_done, input byte_sum, output ready);
endinterface

/* rtl/core/uuencode_line_encoder.sv */
// top level of the uuencode line encoder
//
//  channel   dir  handshake      payload
//  i_byte    in   valid/ready    data_byte[7:0]
//  o_char    out  valid/ready    out_char[6:0], last_of_run, block_done, byte_sum[23:0]
//  i_cfg     in   write enable   i_cfg_wdata[15:0] = block_bytes
//
//  a byte waits in the input register until it can move on, then its 0 to 7 characters are built
//  in one pass and loaded into the result register, which sends one char per beat
//  a byte is taken every cycle while bursts are empty; otherwise the next byte waits until
//  the single result register is empty or on its last beat
//  reset is synchronous active low; block_bytes returns to 512 and no block is open
//  a stalled output holds its char; the input register keeps one byte in reserve
module uuencode_line_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    uule_byte_if.sink   i_byte,
    uule_char_if.source o_char
);

    // block length register, sampled when a block's first byte is processed
    logic [15:0] r_block_bytes;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    logic             w_free;
    logic             w_move;
    logic             w_load;
    uule_pkg::t_burst w_burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= uule_pkg::BLOCK_BYTES_RST;
        end else if (i_cfg_we) begin
            r_block_bytes <= i_cfg_wdata;
        end
    end

    // the held byte moves on once the result register is empty or on its last beat
    assign w_move       = r_in_valid && w_free;
    assign i_byte.ready = !r_in_valid || w_free;
    // bytes that complete nothing only update the state
    assign w_load       = w_move && (w_burst.count != uule_pkg::CNT_W'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
        end
    end

    // state update and character building
    uule_step u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_move        (w_move),
        .i_byte        (r_in_byte),
        .i_block_bytes (r_block_bytes),
        .o_burst       (w_burst)
    );

    // result register and character sequencing
    uule_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_burst (w_burst),
        .o_free  (w_free),
        .o_char  (o_char)
    );

    // end of block always closes the run of its byte
    a_done_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char.valid && o_char.block_done |-> o_char.last_of_run)
        else $error("block_done without last_of_run");

    // the sum is only shown on the final character of a block
    a_sum_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char.valid && !o_char.block_done |-> o_char.byte_sum == 24'd0)
        else $error("byte_sum nonzero outside block end");

    // a held byte that cannot move stays put
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_move |=> r_in_valid && $stable(r_in_byte))
        else $error("input register lost a byte");

    // a new burst is only loaded when the previous one is gone or finishing
    a_load_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char.valid && !o_char.last_of_run |-> !w_load)
        else $error("burst overwritten");

endmodule

/* rtl/core/uule_step.sv */
// encoder state and the per-byte character burst
module uule_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_move,
    input  logic [7:0]          i_byte,
    input  logic [15:0]         i_block_bytes,
    output uule_pkg::t_burst    o_burst
);

    logic [15:0] r_held, n_held;
    logic [1:0]  r_gp, n_gp;
    logic [5:0]  r_lp, n_lp;
    logic [15:0] r_left, n_left;
    logic [23:0] r_sum, n_sum;

    logic [15:0] w_held0, w_left0, w_left1;
    logic [1:0]  w_gp0, w_gp1;
    logic [5:0]  w_lp0, w_lp1, w_len;
    logic [23:0] w_sum0, w_sum1;
    logic        w_open, w_block_end, w_line_end, w_emit;
    logic [7:0]  w_a, w_b, w_c;
    logic [6:0]  w_lenc, w_d0, w_d1, w_d2, w_d3;

    always_comb begin
        // a new block starts when nothing is left of the previous one
        if (r_left == 16'd0) begin
            w_left0 = (i_block_bytes != 16'd0) ? i_block_bytes : 16'd1;
            w_sum0  = 24'd0;
            w_lp0   = 6'd0;
            w_gp0   = 2'd0;
            w_held0 = 16'd0;
        end else begin
            w_left0 = r_left;
            w_sum0  = r_sum;
            w_lp0   = r_lp;
            w_gp0   = r_gp;
            w_held0 = r_held;
        end

        w_open = (w_lp0 == 6'd0) && (w_gp0 == 2'd0);
        w_len  = (w_left0 < 16'(uule_pkg::LINE_BYTES)) ? w_left0[5:0]
                                                        : 6'(uule_pkg::LINE_BYTES);

        w_sum1  = w_sum0 + {16'd0, i_byte};
        w_left1 = w_left0 - 16'd1;
        w_lp1   = w_lp0 + 6'd1;
        w_gp1   = w_gp0 + 2'd1;

        w_block_end = (w_left1 == 16'd0);
        w_line_end  = w_block_end || (w_lp1 >= 6'(uule_pkg::LINE_BYTES));
        w_emit      = (w_gp1 == 2'd3) || w_line_end;

        case (w_gp1)
            2'd1: begin
                w_a = i_byte;
                w_b = 8'd0;
                w_c = 8'd0;
            end
            2'd2: begin
                w_a = w_held0[15:8];
                w_b = i_byte;
                w_c = 8'd0;
            end
            default: begin
                w_a = w_held0[15:8];
                w_b = w_held0[7:0];
                w_c = i_byte;
            end
        endcase

        w_lenc = uule_pkg::enc6(w_len);
        w_d0   = uule_pkg::enc6(w_a[7:2]);
        w_d1   = uule_pkg::enc6({w_a[1:0], w_b[7:4]});
        w_d2   = uule_pkg::enc6({w_b[3:0], w_c[7:6]});
        w_d3   = uule_pkg::enc6(w_c[5:0]);

        // slot order: length char if the line opens, then data, then cr lf
        if (w_open) begin
            o_burst.chars = {uule_pkg::CHAR_LF, uule_pkg::CHAR_CR,
                             w_d3, w_d2, w_d1, w_d0, w_lenc};
        end else begin
            o_burst.chars = {uule_pkg::CHAR_LF, uule_pkg::CHAR_LF, uule_pkg::CHAR_CR,
                             w_d3, w_d2, w_d1, w_d0};
        end
        o_burst.count = (w_open ? uule_pkg::CNT_W'(1) : uule_pkg::CNT_W'(0))
                      + (w_emit ? uule_pkg::CNT_W'(4) : uule_pkg::CNT_W'(0))
                      + (w_line_end ? uule_pkg::CNT_W'(2) : uule_pkg::CNT_W'(0));
        o_burst.done  = w_block_end;
        o_burst.sum   = w_block_end ? w_sum1 : 24'd0;

        n_left = w_left1;
        n_sum  = w_block_end ? 24'd0 : w_sum1;
        n_lp   = w_line_end ? 6'd0 : w_lp1;
        n_gp   = w_emit ? 2'd0 : w_gp1;
        if (w_emit) begin
            n_held = 16'd0;
        end else if (w_gp1 == 2'd1) begin
            n_held = {i_byte, 8'd0};
        end else begin
            n_held = {w_held0[15:8], i_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 16'd0;
            r_gp   <= 2'd0;
            r_lp   <= 6'd0;
            r_left <= 16'd0;
            r_sum  <= 24'd0;
        end else if (i_move) begin
            r_held <= n_held;
            r_gp   <= n_gp;
            r_lp   <= n_lp;
            r_left <= n_left;
            r_sum  <= n_sum;
        end
    end

endmodule

/* rtl/core/uule_emit.sv */
// result register: sends a burst one character per beat
module uule_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  uule_pkg::t_burst    i_burst,
    output logic                o_free,
    uule_char_if.source         o_char
);

    logic [uule_pkg::MAX_CHARS-1:0][6:0] r_chars;
    logic [uule_pkg::CNT_W-1:0]          r_cnt;
    logic                                r_done;
    logic [23:0]                         r_sum;
    logic                                w_last, w_beat;

    assign w_last = (r_cnt == uule_pkg::CNT_W'(1));
    assign w_beat = o_char.valid && o_char.ready;
    assign o_free = (r_cnt == uule_pkg::CNT_W'(0)) || (w_last && o_char.ready);

    assign o_char.valid       = (r_cnt != uule_pkg::CNT_W'(0));
    assign o_char.out_char    = r_chars[0];
    assign o_char.last_of_run = w_last;
    assign o_char.block_done  = w_last && r_done;
    assign o_char.byte_sum    = (w_last && r_done) ? r_sum : 24'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.count;
        end else if (w_beat) begin
            r_cnt <= r_cnt - uule_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_chars <= i_burst.chars;
            r_done  <= i_burst.done;
            r_sum   <= i_burst.sum;
        end else if (w_beat) begin
            r_chars <= {7'd0, r_chars[uule_pkg::MAX_CHARS-1:1]};
        end
    end

endmodule
